### hw/rtl/pidaw_pkg.sv
`timescale 1ns / 1ps

package pidaw_pkg;

   // Default sizes of the data path.
   localparam int DATA_WIDTH_DEF     = 16;
   localparam int GAIN_FRAC_BITS_DEF = 12;

   // Fixed formats of gains and internal state.
   localparam int GAIN_W        = 16;
   localparam int INT_FRAC_BITS = 16;
   localparam int PROP_BITS     = 24;
   localparam int CLAMP_BITS    = 25;
   localparam int INTEG_BITS    = 32;
   localparam int CSR_INDEX_W   = 3;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PROP_GAIN   = 3'd0,
      CSR_INT_GAIN    = 3'd1,
      CSR_WINDUP_GAIN = 3'd2,
      CSR_DERIV_GAIN  = 3'd3,
      CSR_UPPER_LIMIT = 3'd4,
      CSR_LOWER_LIMIT = 3'd5,
      CSR_NONNEG_INT  = 3'd6
   } csr_index_type;

   // Sequencer states, one-hot.
   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_MUL_P = 8'b0000_0010,
      ST_PROP  = 8'b0000_0100,
      ST_MUL_I = 8'b0000_1000,
      ST_MUL_D = 8'b0001_0000,
      ST_INTEG = 8'b0010_0000,
      ST_SUM   = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

endpackage

### hw/rtl/pid_antiwindup_controller.sv
`timescale 1ns / 1ps

// Positional PID regulator with clamp-error feedback anti-windup.
//
// Channels: req_ carries one sample item (reference and feedback in tdata,
// the clear flag in tuser). rsp_ returns one item per request: the clamped
// output and a flag that tells whether the limits were hit. csr_ writes the
// gains, output limits and the nonnegative-integral flag; it is always ready
// and must only be used while no item is in flight.
//
// Sequencing: a control step reaches the result register through seven
// sequencer steps that pass the four products (kp, kc, ki, kd) through one
// shared 17 x 25 bit multiplier (at the default data width). The next item
// is accepted only once the sequencer is back in idle after the result
// register is loaded. A clear item goes from idle straight to the output
// step. One item is worked on at a time.
//
// Reset clears the controller state, loads the register defaults (zero
// gains, full-scale limits) and empties the result register. When the
// receiver stalls, the finished result waits in the output register; a new
// item is still accepted, and it halts before its last step until the
// waiting result has been taken.
module pid_antiwindup_controller
   import pidaw_pkg::*;
#(
   parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Sample items.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata: reference, feedback (zero padded to bytes)
   input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]  req_tdata,
   // tuser: mode (1 clears the controller state)
   input  logic [0:0]                         req_tuser,
   // Result items.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata: control_out, clamped (zero padded to bytes)
   output logic [((DATA_WIDTH+8)/8)*8-1:0]    rsp_tdata,
   // Register writes.
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [CSR_INDEX_W-1:0]             csr_index,
   input  logic [((DATA_WIDTH > GAIN_W) ? DATA_WIDTH : GAIN_W)-1:0] csr_data
);

   localparam int DW    = DATA_WIDTH;
   localparam int GF    = GAIN_FRAC_BITS;
   localparam int RSP_W = ((DW+8)/8)*8;
   // Multiplier operand B, product, accumulator and sum widths.
   localparam int MB     = (DW + 1 > CLAMP_BITS) ? DW + 1 : CLAMP_BITS;
   localparam int PW     = GAIN_W + 1 + MB;
   localparam int ACC_W  = PW + 2;
   localparam int PRE_A  = PROP_BITS + GAIN_W - GF + 3;
   localparam int PRE_W  = (PRE_A > DW + 1) ? PRE_A : DW + 1;
   localparam int DIF_W  = PRE_W + 1;

   // Saturation bounds, each at the width of the value it bounds.
   localparam logic signed [PW-1:0] PROP_MAX =
      PW'((64'sd1 <<< (PROP_BITS-1)) - 64'sd1);
   localparam logic signed [PW-1:0] PROP_MIN = ~PROP_MAX;
   localparam logic signed [ACC_W-1:0] INTEG_MAX =
      ACC_W'((64'sd1 <<< (INTEG_BITS-1)) - 64'sd1);
   localparam logic signed [ACC_W-1:0] INTEG_MIN = ~INTEG_MAX;
   localparam logic signed [DIF_W-1:0] CLAMP_MAX =
      DIF_W'((64'sd1 <<< (CLAMP_BITS-1)) - 64'sd1);
   localparam logic signed [DIF_W-1:0] CLAMP_MIN = ~CLAMP_MAX;

   // Configuration registers.
   logic [GAIN_W-1:0]        prop_gain_ff;
   logic [GAIN_W-1:0]        int_gain_ff;
   logic [GAIN_W-1:0]        windup_gain_ff;
   logic [GAIN_W-1:0]        deriv_gain_ff;
   logic signed [DW-1:0]     upper_limit_ff;
   logic signed [DW-1:0]     lower_limit_ff;
   logic                     nonneg_ff;

   // Controller state.
   logic signed [INTEG_BITS-1:0] integral_ff, integral_in;
   logic signed [CLAMP_BITS-1:0] clamp_err_ff, clamp_err_in;
   logic signed [PROP_BITS-1:0]  last_prop_ff, last_prop_in;

   // Sequencer and working registers.
   state_type                state_ff, state_in;
   logic                     mode_ff;
   logic signed [DW:0]       err_ff;
   logic signed [PW-1:0]     prod_ff;
   logic signed [PROP_BITS-1:0] up_ff, up_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [PRE_W-1:0]  presat_ff, presat_in;

   // Result register.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0]     rsp_out_ff, rsp_out_in;
   logic                     rsp_clamp_ff, rsp_clamp_in;

   logic                     req_fire;
   logic                     out_free;
   logic signed [DW-1:0]     req_ref;
   logic signed [DW-1:0]     req_fdb;
   logic [GAIN_W-1:0]        mul_a;
   logic signed [MB-1:0]     mul_b;
   logic signed [PW-1:0]     mul_p;
   logic                     mul_en;
   logic signed [PW-1:0]     prop_shift;
   logic signed [ACC_W-1:0]  integ_sat;
   logic signed [PRE_W-1:0]  upper_ext;
   logic signed [PRE_W-1:0]  lower_ext;
   logic signed [DIF_W-1:0]  clamp_diff;
   logic signed [DW-1:0]     res_val;
   logic                     res_clamp;

   assign req_ref    = req_tdata[DW-1:0];
   assign req_fdb    = req_tdata[2*DW-1:DW];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_clamp_ff, rsp_out_ff});

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff   <= '0;
         int_gain_ff    <= '0;
         windup_gain_ff <= '0;
         deriv_gain_ff  <= '0;
         upper_limit_ff <= {1'b0, {(DW-1){1'b1}}};
         lower_limit_ff <= {1'b1, {(DW-1){1'b0}}};
         nonneg_ff      <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PROP_GAIN:   prop_gain_ff   <= csr_data[GAIN_W-1:0];
            CSR_INT_GAIN:    int_gain_ff    <= csr_data[GAIN_W-1:0];
            CSR_WINDUP_GAIN: windup_gain_ff <= csr_data[GAIN_W-1:0];
            CSR_DERIV_GAIN:  deriv_gain_ff  <= csr_data[GAIN_W-1:0];
            CSR_UPPER_LIMIT: upper_limit_ff <= csr_data[DW-1:0];
            CSR_LOWER_LIMIT: lower_limit_ff <= csr_data[DW-1:0];
            CSR_NONNEG_INT:  nonneg_ff      <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Shared multiplier operand selection: one gain times one signed term.
   always_comb begin
      mul_en = 1'b1;
      mul_a  = prop_gain_ff;
      mul_b  = MB'(err_ff);
      unique case (state_ff)
         ST_MUL_P: begin
            mul_a = prop_gain_ff;
            mul_b = MB'(err_ff);
         end
         ST_PROP: begin
            mul_a = windup_gain_ff;
            mul_b = MB'(clamp_err_ff);
         end
         ST_MUL_I: begin
            mul_a = int_gain_ff;
            mul_b = MB'(up_ff);
         end
         ST_MUL_D: begin
            mul_a = deriv_gain_ff;
            mul_b = MB'(up_ff) - MB'(last_prop_ff);
         end
         default: mul_en = 1'b0;
      endcase
   end

   assign mul_p = $signed({1'b0, mul_a}) * mul_b;

   // Proportional term after the gain scaling, then 24-bit saturation.
   assign prop_shift = prod_ff >>> GF;

   always_comb begin
      if (prop_shift > PROP_MAX) begin
         up_in = PROP_BITS'(PROP_MAX);
      end else if (prop_shift < PROP_MIN) begin
         up_in = PROP_BITS'(PROP_MIN);
      end else begin
         up_in = PROP_BITS'(prop_shift);
      end
   end

   // Integral accumulation in two steps over the shared product register.
   always_comb begin
      acc_in = acc_ff;
      if (state_ff == ST_MUL_I) begin
         acc_in = ACC_W'(integral_ff) + ACC_W'(prod_ff);
      end else if (state_ff == ST_MUL_D) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   // Integral saturation and the optional floor at zero.
   always_comb begin
      priority if (acc_ff > INTEG_MAX) begin
         integ_sat = INTEG_MAX;
      end else if (acc_ff < INTEG_MIN) begin
         integ_sat = INTEG_MIN;
      end else begin
         integ_sat = acc_ff;
      end
      if (nonneg_ff && integ_sat[ACC_W-1]) begin
         integ_sat = '0;
      end
   end

   // Sum of proportional, integer part of integral and derivative terms.
   assign presat_in = PRE_W'(up_ff) + PRE_W'(integral_ff >>> INT_FRAC_BITS)
                      + PRE_W'(prod_ff >>> GF);

   // Output limiting; the upper limit is tested first.
   assign upper_ext = PRE_W'(upper_limit_ff);
   assign lower_ext = PRE_W'(lower_limit_ff);

   always_comb begin
      priority if (presat_ff > upper_ext) begin
         res_val   = upper_limit_ff;
         res_clamp = 1'b1;
      end else if (presat_ff < lower_ext) begin
         res_val   = lower_limit_ff;
         res_clamp = 1'b1;
      end else begin
         res_val   = DW'(presat_ff);
         res_clamp = 1'b0;
      end
   end

   assign clamp_diff = DIF_W'(res_val) - DIF_W'(presat_ff);

   // Sequencer and state updates.
   always_comb begin
      state_in     = state_ff;
      integral_in  = integral_ff;
      clamp_err_in = clamp_err_ff;
      last_prop_in = last_prop_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_out_in   = rsp_out_ff;
      rsp_clamp_in = rsp_clamp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = req_tuser[0] ? ST_OUT : ST_MUL_P;
            end
         end
         ST_MUL_P: state_in = ST_PROP;
         ST_PROP:  state_in = ST_MUL_I;
         ST_MUL_I: state_in = ST_MUL_D;
         ST_MUL_D: state_in = ST_INTEG;
         ST_INTEG: begin
            integral_in = INTEG_BITS'(integ_sat);
            state_in    = ST_SUM;
         end
         ST_SUM:   state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (mode_ff) begin
                  integral_in  = '0;
                  clamp_err_in = '0;
                  last_prop_in = '0;
                  rsp_out_in   = '0;
                  rsp_clamp_in = 1'b0;
               end else begin
                  priority if (clamp_diff > CLAMP_MAX) begin
                     clamp_err_in = CLAMP_BITS'(CLAMP_MAX);
                  end else if (clamp_diff < CLAMP_MIN) begin
                     clamp_err_in = CLAMP_BITS'(CLAMP_MIN);
                  end else begin
                     clamp_err_in = CLAMP_BITS'(clamp_diff);
                  end
                  last_prop_in = up_ff;
                  rsp_out_in   = res_val;
                  rsp_clamp_in = res_clamp;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         integral_ff  <= '0;
         clamp_err_ff <= '0;
         last_prop_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         integral_ff  <= integral_in;
         clamp_err_ff <= clamp_err_in;
         last_prop_ff <= last_prop_in;
      end
   end

   // Working and result registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff <= req_tuser[0];
         err_ff  <= (DW+1)'(req_ref) - (DW+1)'(req_fdb);
      end
      if (mul_en) begin
         prod_ff <= mul_p;
      end
      if (state_ff == ST_PROP) begin
         up_ff <= up_in;
      end
      acc_ff <= acc_in;
      if (state_ff == ST_SUM) begin
         presat_ff <= presat_in;
      end
      rsp_out_ff   <= rsp_out_in;
      rsp_clamp_ff <= rsp_clamp_in;
   end

endmodule
